FILE: design/retransmit_frame_window_tracker_assert.svh
`ifndef RETRANSMIT_FRAME_WINDOW_TRACKER_ASSERT_SVH
`define RETRANSMIT_FRAME_WINDOW_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rfwt_pkg.sv
package rfwt_pkg;

    localparam int WINDOW_DEFAULT = 64;

    localparam int SEQ_W     = 32;
    localparam int TIME_W    = 64;
    localparam int LIMIT_W   = 3;
    localparam int STATUS_W  = 3;
    localparam int REQ_W     = 2;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SENT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACK   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd3;

    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RETRANSMIT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ACKED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'd1;

    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 64'd200_000_000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 3'd4;
    localparam logic [LIMIT_W-1:0] RESENDS_MAX   = 3'd7;

endpackage

FILE: design/rfwt_slot_mod.sv
module rfwt_slot_mod #(
    parameter int WINDOW = rfwt_pkg::WINDOW_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rfwt_pkg::SEQ_W-1:0] value,
    output logic                       done,
    output logic [$clog2(WINDOW)-1:0]  slot
);

    localparam int SEQ_W = rfwt_pkg::SEQ_W;
    localparam int PW    = 2 * SEQ_W;
    localparam int SW    = $clog2(WINDOW);
    localparam int RW    = SW + 1;
    localparam logic [SEQ_W-1:0] RECIP = SEQ_W'((64'd1 << SEQ_W) / WINDOW);
    localparam logic [RW-1:0]    WIN_N = RW'(WINDOW);

    logic [2:0]       stage_reg;
    logic             done_reg;
    logic [SEQ_W-1:0] x_reg;
    logic [PW-1:0]    prod_reg;
    logic [RW-1:0]    r_reg;
    logic [SW-1:0]    slot_reg;

    logic [RW-1:0] q_low;
    logic [RW-1:0] qw;
    logic [RW-1:0] r_next;
    logic [RW-1:0] r_fix;

    // The reciprocal quotient is at most one short, so the remainder
    // stays below twice the window and one subtraction corrects it.
    assign q_low  = prod_reg[SEQ_W +: RW];
    assign qw     = q_low * WIN_N;
    assign r_next = x_reg[RW-1:0] - qw;
    assign r_fix  = (r_reg >= WIN_N) ? (r_reg - WIN_N) : r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= {stage_reg[1:0], start};
            done_reg  <= stage_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= value;
        end
        if (stage_reg[0]) begin
            prod_reg <= PW'(x_reg) * PW'(RECIP);
        end
        if (stage_reg[1]) begin
            r_reg <= r_next;
        end
        if (stage_reg[2]) begin
            slot_reg <= r_fix[SW-1:0];
        end
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

FILE: design/retransmit_frame_window_tracker.sv
// Sender-side window of outstanding frames. Per-slot sequence, resend count
// and send stamp live in two single-port memories with registered read
// data; busy flags are flip-flops cleared by reset. One item is in work
// at a time. An ack range clears one slot per acknowledged sequence, at
// most WINDOW, and a timeout check walks all slots in turn through the
// memory port and reads each busy one. Frame sent and ack range first map
// the sequence to its slot in a reciprocal multiply unit. Results leave
// through an output register, and a stalled result holds back only the
// next step that needs to emit.
`include "retransmit_frame_window_tracker_assert.svh"

module retransmit_frame_window_tracker #(
    parameter int WINDOW = rfwt_pkg::WINDOW_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rfwt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [rfwt_pkg::TIME_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Bits from 0: sent_seq[31:0], ack_start[63:32], ack_count[71:64],
    // now_ticks[135:72].
    input  logic [135:0]                   s_tdata,
    // Bits from 0: req_type[1:0].
    input  logic [rfwt_pkg::REQ_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Bits from 0: frame_seq[31:0].
    output logic [rfwt_pkg::SEQ_W-1:0]     m_tdata,
    // Bits from 0: status[2:0].
    output logic [rfwt_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    localparam int SEQ_W    = rfwt_pkg::SEQ_W;
    localparam int TIME_W   = rfwt_pkg::TIME_W;
    localparam int LIMIT_W  = rfwt_pkg::LIMIT_W;
    localparam int STATUS_W = rfwt_pkg::STATUS_W;
    localparam int REQ_W    = rfwt_pkg::REQ_W;
    localparam int COUNT_W  = rfwt_pkg::COUNT_W;
    localparam int SW       = $clog2(WINDOW);
    localparam int CW       = $clog2(WINDOW + 1);
    localparam int AW       = SEQ_W + LIMIT_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC    = 4'd1;
    localparam logic [3:0] S_MOD      = 4'd2;
    localparam logic [3:0] S_SENT_WR  = 4'd3;
    localparam logic [3:0] S_ACK_WALK = 4'd4;
    localparam logic [3:0] S_ACK_DONE = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_EV  = 4'd7;
    localparam logic [3:0] S_SCAN_END = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [SEQ_W-1:0] sent_reg, sent_next;
    logic [SEQ_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CW-1:0] left_reg, left_next;
    logic [TIME_W-1:0] timeout_reg, timeout_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [SW-1:0] next_slot_reg, next_slot_next;
    logic [WINDOW-1:0] busy_reg, busy_next;
    logic [SW-1:0] walk_slot_reg, walk_slot_next;
    logic [SEQ_W-1:0] walk_seq_reg, walk_seq_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [SEQ_W-1:0] pend_seq_reg, pend_seq_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SEQ_W-1:0] m_seq_reg, m_seq_next;
    logic m_last_reg, m_last_next;

    logic [AW-1:0]     mem_a [WINDOW];
    logic [TIME_W-1:0] mem_s [WINDOW];
    logic [AW-1:0]     rda_reg;
    logic [TIME_W-1:0] rds_reg;

    logic              a_en, a_we;
    logic [SW-1:0]     a_addr;
    logic [AW-1:0]     a_wdata;
    logic              s_en, s_we;
    logic [SW-1:0]     s_addr;

    logic              mod_start;
    logic [SEQ_W-1:0]  mod_value;
    logic              mod_done;
    logic [SW-1:0]     mod_slot;

    logic              out_free;
    logic [SW-1:0]     scan_slot;
    logic [LIMIT_W-1:0] res_old;
    logic [LIMIT_W-1:0] res_new;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic [COUNT_W-1:0] in_count;

    rfwt_slot_mod #(
        .WINDOW(WINDOW)
    ) u_slot_mod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mod_start),
        .value  (mod_value),
        .done   (mod_done),
        .slot   (mod_slot)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_slot = scan_reg[SW-1:0];
    assign res_old   = rda_reg[AW-1:SEQ_W];
    assign res_new   = (res_old == rfwt_pkg::RESENDS_MAX) ? res_old : (res_old + LIMIT_W'(1));
    assign elapsed   = now_reg - rds_reg;
    assign due       = (elapsed > timeout_reg) && (now_reg > rds_reg);
    assign in_count  = s_tdata[71:64];
    assign mod_value = (s_tuser == rfwt_pkg::REQ_SENT) ? s_tdata[31:0] : s_tdata[63:32];

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        sent_next        = sent_reg;
        start_next       = start_reg;
        now_next         = now_reg;
        left_next        = left_reg;
        timeout_next     = timeout_reg;
        limit_next       = limit_reg;
        next_seq_next    = next_seq_reg;
        next_slot_next   = next_slot_reg;
        busy_next        = busy_reg;
        walk_slot_next   = walk_slot_reg;
        walk_seq_next    = walk_seq_reg;
        scan_next        = scan_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_seq_next    = pend_seq_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_status_next    = m_status_reg;
        m_seq_next       = m_seq_reg;
        m_last_next      = m_last_reg;
        a_en             = 1'b0;
        a_we             = 1'b0;
        a_addr           = '0;
        a_wdata          = '0;
        s_en             = 1'b0;
        s_we             = 1'b0;
        s_addr           = '0;
        mod_start        = 1'b0;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_idx)
                rfwt_pkg::CFG_TIMEOUT: timeout_next = cfg_wdata;
                rfwt_pkg::CFG_LIMIT:   limit_next   = cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next   = s_tuser;
                    sent_next  = s_tdata[31:0];
                    start_next = s_tdata[63:32];
                    now_next   = s_tdata[135:72];
                    left_next  = (in_count > COUNT_W'(WINDOW)) ? CW'(WINDOW) : CW'(in_count);
                    case (s_tuser)
                        rfwt_pkg::REQ_ALLOC: state_next = S_ALLOC;
                        rfwt_pkg::REQ_SENT, rfwt_pkg::REQ_ACK: begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                        rfwt_pkg::REQ_CHECK: begin
                            scan_next  = '0;
                            state_next = S_SCAN_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_seq_next    = next_seq_reg;
                    m_last_next   = 1'b1;
                    if (busy_reg[next_slot_reg]) begin
                        m_status_next = rfwt_pkg::ST_REFUSED;
                    end else begin
                        m_status_next            = rfwt_pkg::ST_GRANTED;
                        busy_next[next_slot_reg] = 1'b1;
                        a_en                     = 1'b1;
                        a_we                     = 1'b1;
                        a_addr                   = next_slot_reg;
                        a_wdata                  = {LIMIT_W'(0), next_seq_reg};
                        next_seq_next            = next_seq_reg + SEQ_W'(1);
                        if (next_seq_reg == '1 || next_slot_reg == SW'(WINDOW - 1)) begin
                            next_slot_next = '0;
                        end else begin
                            next_slot_next = next_slot_reg + SW'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    if (req_reg == rfwt_pkg::REQ_SENT) begin
                        a_en       = 1'b1;
                        a_addr     = mod_slot;
                        state_next = S_SENT_WR;
                    end else begin
                        walk_slot_next = mod_slot;
                        walk_seq_next  = start_reg;
                        state_next     = S_ACK_WALK;
                    end
                end
            end
            S_SENT_WR: begin
                if (busy_reg[mod_slot] && rda_reg[SEQ_W-1:0] == sent_reg) begin
                    s_en   = 1'b1;
                    s_we   = 1'b1;
                    s_addr = mod_slot;
                end
                state_next = S_IDLE;
            end
            S_ACK_WALK: begin
                if (left_reg == '0) begin
                    state_next = S_ACK_DONE;
                end else begin
                    busy_next[walk_slot_reg] = 1'b0;
                    left_next                = left_reg - CW'(1);
                    walk_seq_next            = walk_seq_reg + SEQ_W'(1);
                    if (walk_seq_reg == '1 || walk_slot_reg == SW'(WINDOW - 1)) begin
                        walk_slot_next = '0;
                    end else begin
                        walk_slot_next = walk_slot_reg + SW'(1);
                    end
                end
            end
            S_ACK_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = rfwt_pkg::ST_ACKED;
                    m_seq_next    = start_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (scan_reg == CW'(WINDOW)) begin
                    state_next = S_SCAN_END;
                end else if (busy_reg[scan_slot]) begin
                    a_en       = 1'b1;
                    a_addr     = scan_slot;
                    s_en       = 1'b1;
                    s_addr     = scan_slot;
                    state_next = S_SCAN_EV;
                end else begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            S_SCAN_EV: begin
                if (!due) begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_status_next = pend_status_reg;
                        m_seq_next    = pend_seq_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_seq_next   = rda_reg[SEQ_W-1:0];
                    a_en            = 1'b1;
                    a_we            = 1'b1;
                    a_addr          = scan_slot;
                    a_wdata         = {res_new, rda_reg[SEQ_W-1:0]};
                    if (res_new < limit_reg) begin
                        pend_status_next = rfwt_pkg::ST_RETRANSMIT;
                        s_en             = 1'b1;
                        s_we             = 1'b1;
                        s_addr           = scan_slot;
                    end else begin
                        pend_status_next = rfwt_pkg::ST_LIMIT;
                    end
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg) begin
                        m_status_next = pend_status_reg;
                        m_seq_next    = pend_seq_reg;
                    end else begin
                        m_status_next = rfwt_pkg::ST_IDLE;
                        m_seq_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            if (a_we) begin
                mem_a[a_addr] <= a_wdata;
            end else begin
                rda_reg <= mem_a[a_addr];
            end
        end
        if (s_en) begin
            if (s_we) begin
                mem_s[s_addr] <= now_reg;
            end else begin
                rds_reg <= mem_s[s_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            timeout_reg    <= rfwt_pkg::TIMEOUT_RESET;
            limit_reg      <= rfwt_pkg::LIMIT_RESET;
            next_seq_reg   <= SEQ_W'(1);
            next_slot_reg  <= SW'(1);
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            limit_reg      <= limit_next;
            next_seq_reg   <= next_seq_next;
            next_slot_reg  <= next_slot_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        sent_reg        <= sent_next;
        start_reg       <= start_next;
        now_reg         <= now_next;
        left_reg        <= left_next;
        walk_slot_reg   <= walk_slot_next;
        walk_seq_reg    <= walk_seq_next;
        scan_reg        <= scan_next;
        pend_status_reg <= pend_status_next;
        pend_seq_reg    <= pend_seq_next;
        m_status_reg    <= m_status_next;
        m_seq_reg       <= m_seq_next;
        m_last_reg      <= m_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_seq_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `RFWT_ASSERT_NEXT(a_grant_sets_busy, (state_reg == S_ALLOC) && out_free && !busy_reg[next_slot_reg], busy_reg[$past(next_slot_reg)], "granted slot is not busy")
    `RFWT_ASSERT_SAME(a_single_result_last, m_tvalid && (m_tuser == rfwt_pkg::ST_GRANTED || m_tuser == rfwt_pkg::ST_REFUSED || m_tuser == rfwt_pkg::ST_ACKED || m_tuser == rfwt_pkg::ST_IDLE), m_tlast, "single result without last")
    `RFWT_ASSERT_SAME(a_pending_in_scan, pend_valid_reg, state_reg == S_SCAN_RD || state_reg == S_SCAN_EV || state_reg == S_SCAN_END, "held scan result outside a scan")
    `RFWT_ASSERT_SAME(a_eval_after_read, state_reg == S_SCAN_EV, $past(state_reg) == S_SCAN_RD || $past(state_reg) == S_SCAN_EV, "slot evaluated without a read")

endmodule
